// ===== rtl/core/psw_pkg.sv =====
// Package: shared payload types and status codes for the placement swap block.
package psw_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] site_a_col;
    logic [5:0] site_a_row;
    logic [5:0] site_b_col;
    logic [5:0] site_b_row;
    logic [9:0] cell_index;
    logic       pin_ends_net;
  } req_t;

  typedef struct packed {
    logic [18:0] wirelength;
    logic [1:0]  status;
  } rsp_t;

  localparam logic [1:0] REQ_PLACE = 2'd0;
  localparam logic [1:0] REQ_PIN   = 2'd1;
  localparam logic [1:0] REQ_SWAP  = 2'd2;
  localparam logic [1:0] REQ_COST  = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOOP = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [18:0] WL_MAX = 19'd524287;

  // Grid and cell store sizes, tied to the 6-bit site and 10-bit cell fields
  localparam int GRID_COLS_MAX = 64;
  localparam int GRID_ROWS_MAX = 64;
  localparam int MAX_CELLS     = 1024;

  // Datapath operation selected by the controller each cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_SWAP_RD,
    OP_SWAP_WR,
    OP_COST_INIT,
    OP_COST_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   respond;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_swap;
    logic       is_cost;
    logic       cost_done;
    logic       scan_clear;
  } dp_stat_t;

endpackage

// ===== rtl/core/placement_swap_wirelength.sv =====
// Top level: placement grid with swap and half-perimeter wirelength.
//  channel   | signals                         | transfer
//  request   | start, busy, req                | start & !busy at clk edge
//  result    | result_valid, result            | one cycle, cannot stall
//  config    | psel penable pwrite paddr pwdata | psel & penable & pwrite
// Place and pin results are answered from the decode state, swaps after a read and then a write step.
// Cost results follow an init step, a walk over all stored pins and an end step.
// After reset a clearing pass over all sites holds busy.
// busy drops in the result cycle, so the next transfer can share that edge; no stalls.
module placement_swap_wirelength #(
  parameter int MAX_PINS      = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  psw_pkg::req_t  req,
  output logic           result_valid,
  output psw_pkg::rsp_t  result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import psw_pkg::*;

  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  logic [6:0] grid_cols, grid_rows;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= 7'd64;
      grid_rows <= 7'd64;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_COLS: grid_cols <= pwdata[6:0];
        REG_ROWS: grid_rows <= pwdata[6:0];
        default:  grid_cols <= grid_cols;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_COLS: prdata = {25'd0, grid_cols};
        default:  prdata = {25'd0, grid_rows};
      endcase
    end
  end

  psw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  psw_datapath #(
    .MAX_PINS(MAX_PINS)
  ) u_dp (
    .clk(clk), .rst(rst), .req(req), .grid_cols(grid_cols), .grid_rows(grid_rows),
    .cmd(cmd), .stat(stat), .done(result_valid), .rsp(result)
  );

  // The controller signals a response only while busy
  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    cmd.respond |-> busy) else $error("respond while idle");
  // Results whose status is not done carry zero wirelength
  a_wl_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_DONE |-> result.wirelength == '0)
    else $error("wirelength on error result");
  // A result follows an accepted request, never an idle cycle
  a_valid_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("stray result");
endmodule

// ===== rtl/core/psw_ctrl.sv =====
// Controller: sequences clear sweep, swap read/write and cost walk.
module psw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output psw_pkg::dp_cmd_t   cmd,
  input  psw_pkg::dp_stat_t  stat
);
  import psw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SWAP_WR, S_COST_INIT, S_COST_RUN, S_COST_END
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '{op: OP_NONE, respond: 1'b0};
    unique case (state)
      S_CLEAR:     cmd.op = OP_NONE;
      S_IDLE:      if (start) cmd.op = OP_LATCH;
      S_DECODE: begin
        if (stat.is_swap) cmd.op = OP_SWAP_RD;
        else if (stat.is_cost) cmd.op = OP_COST_INIT;
        else cmd.respond = 1'b1;
      end
      S_SWAP_WR: begin
        cmd.op = OP_SWAP_WR;
        cmd.respond = 1'b1;
      end
      S_COST_INIT: cmd.op = OP_COST_STEP;
      S_COST_RUN:  cmd.op = OP_COST_STEP;
      S_COST_END:  cmd.respond = 1'b1;
      default:     cmd = '{op: OP_NONE, respond: 1'b0};
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR:     if (stat.scan_clear) state <= S_IDLE;
        S_IDLE:      if (start) state <= S_DECODE;
        S_DECODE: begin
          if (stat.is_swap) state <= S_SWAP_WR;
          else if (stat.is_cost) state <= S_COST_INIT;
          else state <= S_IDLE;
        end
        S_SWAP_WR:   state <= S_IDLE;
        S_COST_INIT: state <= S_COST_RUN;
        S_COST_RUN:  if (stat.cost_done) state <= S_COST_END;
        S_COST_END:  state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/psw_datapath.sv =====
// Datapath: grid, cell position and pin memories, swap unit and cost accumulator.
module psw_datapath #(
  parameter int MAX_PINS      = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  psw_pkg::req_t     req,
  input  logic [6:0]        grid_cols,
  input  logic [6:0]        grid_rows,
  input  psw_pkg::dp_cmd_t  cmd,
  output psw_pkg::dp_stat_t stat,
  output logic              done,
  output psw_pkg::rsp_t     rsp
);
  import psw_pkg::*;

  localparam int CB    = (GRID_COLS_MAX > 1) ? $clog2(GRID_COLS_MAX) : 1;
  localparam int RB    = (GRID_ROWS_MAX > 1) ? $clog2(GRID_ROWS_MAX) : 1;
  localparam int SITES = GRID_COLS_MAX * GRID_ROWS_MAX;
  localparam int SB    = $clog2(SITES);
  localparam int CLB   = $clog2(MAX_CELLS);
  localparam int PB    = $clog2(MAX_PINS);
  localparam int PCB   = $clog2(MAX_PINS + 1);

  // Memories
  logic [CLB-1:0] site_occupant [SITES];
  logic           site_occupied [SITES];
  logic [5:0]     cell_col [MAX_CELLS];
  logic [5:0]     cell_row [MAX_CELLS];
  logic [CLB:0]   pin_mem  [MAX_PINS];   // {last, cell}

  logic [PCB-1:0] pin_count;
  logic [SB:0]    clr_ptr;
  req_t           r;

  // Range checks on latched request
  logic [7:0] lim_c, lim_r;
  logic a_ok, b_ok, cell_ok;
  logic [SB-1:0] sa, sb;
  always_comb begin
    lim_c = (32'(grid_cols) < GRID_COLS_MAX) ? 8'(grid_cols) : 8'(GRID_COLS_MAX);
    lim_r = (32'(grid_rows) < GRID_ROWS_MAX) ? 8'(grid_rows) : 8'(GRID_ROWS_MAX);
    a_ok = (8'(r.site_a_col) < lim_c) && (8'(r.site_a_row) < lim_r);
    b_ok = (8'(r.site_b_col) < lim_c) && (8'(r.site_b_row) < lim_r);
    cell_ok = (32'(r.cell_index) < MAX_CELLS);
    sa = SB'({r.site_a_row[RB-1:0], r.site_a_col[CB-1:0]});
    sb = SB'({r.site_b_row[RB-1:0], r.site_b_col[CB-1:0]});
  end

  assign stat.is_swap = (r.req_type == REQ_SWAP) && a_ok && b_ok && (sa != sb);
  assign stat.is_cost = (r.req_type == REQ_COST);
  // Sweep is finished once the pointer has passed the last site
  assign stat.scan_clear = (clr_ptr == (SB+1)'(SITES));

  // Swap read registers
  logic [CLB-1:0] occ_a, occ_b;
  logic           vld_a, vld_b;

  // Cost walk registers
  logic [PB-1:0]  wp;
  logic [PCB-1:0] wcnt;
  logic           rd_v;
  logic [CLB:0]   pin_q;
  logic           pos_v, pos_last;
  logic [5:0]     px, py;
  logic [7:0]     mnx, mny, mxx, mxy; // max starts at all ones meaning none
  logic [18:0]    sum;
  logic [7:0]     nmnx, nmny, nmxx, nmxy;
  logic [19:0]    dsum;
  rsp_t           rsp_next;

  assign stat.cost_done = !rd_v && !pos_v && (wcnt == '0);

  always_comb begin
    nmnx = (8'(px) < mnx) ? 8'(px) : mnx;
    nmny = (8'(py) < mny) ? 8'(py) : mny;
    nmxx = (mxx == 8'hFF || 8'(px) > mxx) ? 8'(px) : mxx;
    nmxy = (mxy == 8'hFF || 8'(py) > mxy) ? 8'(py) : mxy;
    dsum = 20'(sum) + 20'(nmxx - nmnx) + 20'(nmxy - nmny);
  end

  // Control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_count <= '0;
      clr_ptr   <= '0;
      rd_v      <= 1'b0;
      pos_v     <= 1'b0;
      wcnt      <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (!stat.scan_clear) clr_ptr <= clr_ptr + 1'b1;
      if (cmd.op == OP_NONE && cmd.respond && r.req_type == REQ_PIN &&
          cell_ok && 32'(pin_count) < MAX_PINS)
        pin_count <= pin_count + 1'b1;
      if (cmd.op == OP_COST_INIT) begin
        wcnt <= pin_count;
        rd_v <= 1'b0;
        pos_v <= 1'b0;
      end else if (cmd.op == OP_COST_STEP) begin
        rd_v  <= (wcnt != '0);
        if (wcnt != '0) wcnt <= wcnt - 1'b1;
        pos_v <= rd_v;
      end
    end
  end

  // Site memory: clear sweep, place, swap
  always_ff @(posedge clk) begin
    if (!stat.scan_clear) site_occupied[clr_ptr[SB-1:0]] <= 1'b0;
    else if (cmd.respond && cmd.op == OP_NONE && r.req_type == REQ_PLACE &&
             a_ok && cell_ok) begin
      site_occupied[sa] <= 1'b1;
      site_occupant[sa] <= r.cell_index[CLB-1:0];
    end else if (cmd.op == OP_SWAP_WR && (vld_a || vld_b)) begin
      site_occupied[sa] <= vld_b;
      site_occupied[sb] <= vld_a;
      site_occupant[sa] <= occ_b;
      site_occupant[sb] <= occ_a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SWAP_RD) begin
      occ_a <= site_occupant[sa];
      occ_b <= site_occupant[sb];
      vld_a <= site_occupied[sa];
      vld_b <= site_occupied[sb];
    end
  end

  // Cell positions
  always_ff @(posedge clk) begin
    if (cmd.respond && cmd.op == OP_NONE && r.req_type == REQ_PLACE && a_ok && cell_ok) begin
      cell_col[r.cell_index[CLB-1:0]] <= r.site_a_col;
      cell_row[r.cell_index[CLB-1:0]] <= r.site_a_row;
    end else if (cmd.op == OP_SWAP_WR) begin
      // A cell named by both sites ends up at site b
      if (vld_b && !(vld_a && occ_a == occ_b)) begin
        cell_col[occ_b] <= r.site_a_col;
        cell_row[occ_b] <= r.site_a_row;
      end
      if (vld_a) begin
        cell_col[occ_a] <= r.site_b_col;
        cell_row[occ_a] <= r.site_b_row;
      end
    end
    if (rd_v) begin
      px <= cell_col[pin_q[CLB-1:0]];
      py <= cell_row[pin_q[CLB-1:0]];
      pos_last <= pin_q[CLB];
    end
  end

  // Pin memory
  always_ff @(posedge clk) begin
    if (cmd.respond && cmd.op == OP_NONE && r.req_type == REQ_PIN && cell_ok &&
        32'(pin_count) < MAX_PINS)
      pin_mem[pin_count[PB-1:0]] <= {r.pin_ends_net, r.cell_index[CLB-1:0]};
    pin_q <= pin_mem[wp];
  end

  // Request latch, walk pointer, bounding box accumulation
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) r <= req;
    if (cmd.op == OP_COST_INIT) begin
      wp  <= '0;
      sum <= '0;
      mnx <= {1'b0, grid_cols};
      mny <= {1'b0, grid_rows};
      mxx <= 8'hFF;
      mxy <= 8'hFF;
    end else if (cmd.op == OP_COST_STEP) begin
      if (wcnt != '0) wp <= wp + 1'b1;
      if (pos_v) begin
        if (pos_last) begin
          sum <= (dsum > 20'(WL_MAX)) ? WL_MAX : dsum[18:0];
          mnx <= {1'b0, grid_cols};
          mny <= {1'b0, grid_rows};
          mxx <= 8'hFF;
          mxy <= 8'hFF;
        end else begin
          mnx <= nmnx; mny <= nmny; mxx <= nmxx; mxy <= nmxy;
        end
      end
    end
  end

  // Result fields for the request being answered
  always_comb begin
    rsp_next.wirelength = '0;
    rsp_next.status = ST_DONE;
    unique case (r.req_type)
      REQ_PLACE: if (!(a_ok && cell_ok)) rsp_next.status = ST_ERR;
      REQ_PIN:   if (!cell_ok || 32'(pin_count) >= MAX_PINS) rsp_next.status = ST_ERR;
      REQ_SWAP: begin
        if (!(a_ok && b_ok)) rsp_next.status = ST_ERR;
        else if (sa == sb || cmd.op == OP_SWAP_WR && !vld_a && !vld_b)
          rsp_next.status = ST_NOOP;
      end
      REQ_COST:  rsp_next.wirelength = sum;
      default:   rsp_next.status = ST_DONE;
    endcase
  end

  // Result
  always_ff @(posedge clk) begin
    if (cmd.respond) rsp <= rsp_next;
  end
endmodule
